// File: hdl/sud_pkg.sv
// ----------------------------------------------------------------------------
// sud_pkg: shared types and constants for the sorted union / dedup block
// Store depth, value type, and the records passed between cells.
// ----------------------------------------------------------------------------
package sud_pkg;

    localparam int SET_DEPTH = 32;
    localparam int VALUE_W   = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Chain-wide commands, one per cycle
    typedef struct packed {
        logic insert;    // offer the broadcast value for insertion
        logic shift_dn;  // move every entry one cell toward cell 0
    } t_cell_ctrl;

    // What a cell shows its neighbors
    typedef struct packed {
        t_value value;
        logic   valid;
        logic   ins;     // empty, or holds a value above the offered one
        logic   eq;      // holds the offered value already
    } t_cell_link;

endpackage

// File: hdl/sud_in_if.sv
// ----------------------------------------------------------------------------
// sud_in_if: input item channel
// valid/ready handshake carrying one list value and the final marker.
// ----------------------------------------------------------------------------
interface sud_in_if;
    import sud_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;
    logic   final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

// File: hdl/sud_out_if.sv
// ----------------------------------------------------------------------------
// sud_out_if: result item channel
// valid/ready handshake carrying one sorted value with run flags.
// ----------------------------------------------------------------------------
interface sud_out_if;
    import sud_pkg::*;

    logic   valid;
    logic   ready;
    t_value value_res;
    logic   last_of_run;
    logic   overflow;

    modport source (output valid, output value_res, output last_of_run,
                    output overflow, input ready);
    modport sink   (input valid, input value_res, input last_of_run,
                    input overflow, output ready);
endinterface

// File: hdl/sud_cell.sv
// ----------------------------------------------------------------------------
// sud_cell: one compare-and-shift entry of the sorted store
// Takes the offered value, its left neighbor's entry, or its right neighbor's.
// ----------------------------------------------------------------------------
module sud_cell import sud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_value     i_offer,
    input  t_cell_link i_left,
    input  t_cell_link i_right,
    output t_cell_link o_link
);

    t_value r_value;
    logic   r_valid;

    assign o_link.value = r_value;
    assign o_link.valid = r_valid;
    assign o_link.ins   = !r_valid || (r_value > i_offer);
    assign o_link.eq    = r_valid && (r_value == i_offer);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_dn) begin
            r_value <= i_right.value;
        end else if (i_ctrl.insert) begin
            if (i_left.ins) begin
                r_value <= i_left.value;
            end else if (o_link.ins) begin
                r_value <= i_offer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift_dn) begin
            r_valid <= i_right.valid;
        end else if (i_ctrl.insert) begin
            if (i_left.ins) begin
                r_valid <= i_left.valid;
            end else if (o_link.ins) begin
                r_valid <= 1'b1;
            end
        end
    end

endmodule

// File: hdl/sorted_union_dedup_top.sv
// ----------------------------------------------------------------------------
// sorted_union_dedup_top: sorted set union of two value lists
// Insertion-sort chain of cells with duplicate rejection and ordered drain.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one signed 32-bit value per item; the values of both lists
//   come back to back and the last one has final_item set. Each value is
//   inserted into a chain of SET_DEPTH cells kept in ascending order; a value
//   already held is ignored, a new one arriving while all cells are full is
//   dropped and the run's overflow flag is set.
//   Loading: one item per cycle; the whole chain compares against the
//   broadcast value and shifts in one step.
//   After the final item is accepted i_in.ready drops and the chain drains
//   through cell 0 onto o_out, one item per cycle while o_out.ready is high,
//   smallest first, starting the cycle after the final item; last_of_run marks
//   the largest value and overflow is repeated on every item of the run. The
//   input stays held until the last result of the run is taken.
//   A stalled receiver (o_out.ready low) freezes the chain; the result stays
//   put in cell 0, which is also the output register.
//   The drain empties the cells, so the next run starts clean. Synchronous
//   reset empties every cell, clears the overflow flag and returns to loading.
// ----------------------------------------------------------------------------
module sorted_union_dedup_top import sud_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sud_in_if.sink    i_in,
    sud_out_if.source o_out
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic r_state;
    logic n_state;
    logic r_ovf;
    logic n_ovf;

    t_cell_ctrl w_ctrl;
    t_cell_link w_link [SET_DEPTH];
    t_cell_link w_left [SET_DEPTH];
    t_cell_link w_right[SET_DEPTH];
    logic [SET_DEPTH-1:0] w_valid;
    logic [SET_DEPTH-1:0] w_eq;

    logic w_in_acc;
    logic w_out_acc;
    logic w_hit;
    logic w_full;
    logic w_drop;

    // Neighbor wiring; the chain ends look at an empty, never-inserting cell
    always_comb begin
        for (int i = 0; i < SET_DEPTH; i++) begin
            w_valid[i] = w_link[i].valid;
            w_eq[i]    = w_link[i].eq;
            if (i == 0) begin
                w_left[i] = '0;
            end else begin
                w_left[i] = w_link[i-1];
            end
            if (i == SET_DEPTH - 1) begin
                w_right[i] = '0;
            end else begin
                w_right[i] = w_link[i+1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < SET_DEPTH; g++) begin : g_cell
            sud_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_offer (i_in.value),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    // Input side: loading only
    assign i_in.ready = (r_state == ST_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_hit      = |w_eq;
    assign w_full     = w_valid[SET_DEPTH-1];
    assign w_drop     = w_in_acc && !w_hit && w_full;

    // Output side: cell 0 is the output register
    assign o_out.valid       = (r_state == ST_DRAIN) && w_valid[0];
    assign o_out.value_res   = w_link[0].value;
    assign o_out.last_of_run = !w_valid[1];
    assign o_out.overflow    = r_ovf;
    assign w_out_acc         = o_out.valid && o_out.ready;

    assign w_ctrl.insert   = w_in_acc && !w_hit && !w_full;
    assign w_ctrl.shift_dn = w_out_acc;

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_LOAD: begin
                if (w_drop) begin
                    n_ovf = 1'b1;
                end
                if (w_in_acc && i_in.final_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_out.last_of_run) begin
                    n_state = ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    // Occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("cell chain has a hole");

    // Loading and draining never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while results pending");

    // A final item always starts a non-empty drain
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.final_item) |=> o_out.valid)
        else $error("no result after final item");

    // Drain continues until the last item of the run is taken
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_of_run) |=> o_out.valid)
        else $error("drain stopped before last item");

endmodule

// File: sim/tb_sorted_union_dedup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_union_dedup_top: self-checking bench for the sorted set union
// Feeds runs of signed values through the input channel and predicts the
// sorted, deduplicated drain of each run, including the store-full overflow
// flag. Every result item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_sorted_union_dedup_top;
    import sud_pkg::*;

    // Generous cycle cap on the whole simulation
    localparam int CYCLE_LIMIT = 200000;
    // Quiet cycles after the last result before the verdict
    localparam int TAIL_CYCLES = 2 * SET_DEPTH + 8;

    localparam t_value VAL_MAX = 32'sh7FFF_FFFF;
    localparam t_value VAL_MIN = 32'sh8000_0000;

    // One expected result item
    typedef struct {
        t_value value;
        logic   last;
        logic   ovf;
    } t_sorted_res;

    logic clk;
    logic rst_n;

    sud_in_if  in_if ();
    sud_out_if out_if ();

    sorted_union_dedup_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // ------------------------------------------------------------------------
    // Clock and cycle cap
    // ------------------------------------------------------------------------
    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    int cycle_cnt = 0;

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: a sorted set of distinct values, same depth as the block
    // ------------------------------------------------------------------------
    t_value      set_store [SET_DEPTH];
    int          set_count = 0;
    logic        set_ovf   = 1'b0;
    t_sorted_res sorted_q [$];     // results still owed by the block

    int items_sent  = 0;
    int runs_done   = 0;
    int ovf_runs    = 0;
    int res_checked = 0;
    int fail_cnt    = 0;

    // Insert one accepted value; on the final item queue the whole sorted run
    function automatic void predict_item(input t_value v, input logic fin);
        int          pos;
        int          k;
        t_sorted_res r;
        pos = 0;
        while (pos < set_count && set_store[pos] < v)
            pos++;
        if (!(pos < set_count && set_store[pos] == v)) begin
            if (set_count >= SET_DEPTH) begin
                // new distinct value with no room: dropped, run is flagged
                set_ovf = 1'b1;
            end else begin
                for (k = set_count; k > pos; k--)
                    set_store[k] = set_store[k-1];
                set_store[pos] = v;
                set_count++;
            end
        end
        if (fin) begin
            for (k = 0; k < set_count; k++) begin
                r.value = set_store[k];
                r.last  = (k == set_count - 1);
                r.ovf   = set_ovf;
                sorted_q.push_back(r);
            end
            runs_done++;
            if (set_ovf)
                ovf_runs++;
            set_count = 0;
            set_ovf   = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, driven on the falling edge
    // ------------------------------------------------------------------------
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    always @(negedge clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted item with the oldest expectation
    // ------------------------------------------------------------------------
    t_sorted_res exp_head;

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (sorted_q.size() == 0) begin
                $error("unexpected result item: value_res=%0d last_of_run=%0b overflow=%0b",
                       out_if.value_res, out_if.last_of_run, out_if.overflow);
                fail_cnt++;
            end else begin
                exp_head = sorted_q.pop_front();
                res_checked++;
                if (out_if.value_res !== exp_head.value) begin
                    $error("value_res: expected %0d, got %0d",
                           exp_head.value, out_if.value_res);
                    fail_cnt++;
                end
                if (out_if.last_of_run !== exp_head.last) begin
                    $error("last_of_run: expected %0b, got %0b",
                           exp_head.last, out_if.last_of_run);
                    fail_cnt++;
                end
                if (out_if.overflow !== exp_head.ovf) begin
                    $error("overflow: expected %0b, got %0b",
                           exp_head.ovf, out_if.overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared sender: called at a falling edge, returns at a falling edge.
    // valid stays high into the next call unless that call idles first.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_value v, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid      = 1'b1;
        in_if.value      = v;
        in_if.final_item = fin;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_item(v, fin);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every owed result to come out
    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (sorted_q.size() != 0)
            @(negedge clk);
    endtask

    // Mixed value source: a narrow pool makes duplicates likely, the rest
    // spreads over the full range and the edges of it
    function automatic t_value pick_value();
        t_value v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = t_value'(int'($urandom_range(16)) - 8);
            4, 5, 6:    v = t_value'($urandom);
            7: begin
                case ($urandom_range(3))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            8:       v = VAL_MAX - t_value'($urandom_range(3));
            default: v = VAL_MIN + t_value'($urandom_range(3));
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Range extremes and sign boundary, offered out of order
    task automatic test_extremes();
        send_item(0, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(-1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(1, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b1);
        wait_drained();
    endtask

    // A run made of the final item alone gives exactly one result
    task automatic test_single_item_run();
        send_item(VAL_MIN, 1'b1);
        wait_drained();
        send_item(VAL_MAX, 1'b1);
        wait_drained();
    endtask

    // Repeats within a run, and a final item that is itself a repeat
    task automatic test_duplicates();
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(-5, 1'b0);
        send_item(5, 1'b1);
        wait_drained();
    endtask

    // Store full: a repeat is still just ignored, a new value sets overflow,
    // the final value itself is dropped, and the flag does not leak into the
    // next run
    task automatic test_store_full();
        t_value base;
        int     k;

        // descending fill: every insert lands at the bottom of the chain
        base = t_value'($urandom_range(1 << 20)) - (1 << 19);
        for (k = SET_DEPTH - 1; k >= 0; k--)
            send_item(base + k * 37, 1'b0);
        send_item(base + 3 * 37, 1'b0);             // full, repeat: ignored
        send_item(base - 1, 1'b0);                  // full, new: dropped
        send_item(VAL_MAX, 1'b1);                   // final value dropped too
        wait_drained();

        // next run must come out clean
        send_item(7, 1'b0);
        send_item(-7, 1'b1);
        wait_drained();
    endtask

    // Random runs: mostly short runs with heavy value reuse, now and then a
    // long run; a run is cut to the items left in the budget
    task automatic test_random_runs(input int n_items);
        int start;
        int run_len;
        int k;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(9) == 0)
                run_len = $urandom_range(SET_DEPTH + 8, SET_DEPTH - 4);
            else
                run_len = $urandom_range(12, 1);
            if (run_len > n_items - (items_sent - start))
                run_len = n_items - (items_sent - start);
            for (k = 0; k < run_len; k++)
                send_item(pick_value(), k == run_len - 1);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.value      = '0;
        in_if.final_item = 1'b0;
        out_if.ready     = 1'b0;
        set_store        = '{default: '0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sender sparse, receiver stalling most of the time
        src_idle_pct  = 30;
        sink_idle_pct = 64;
        test_extremes();
        test_single_item_run();
        test_duplicates();
        test_store_full();
        test_random_runs(15);

        // roles swapped
        src_idle_pct  = 64;
        sink_idle_pct = 30;
        test_random_runs(15);

        // full rate both ways
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_runs(15);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sorted_q.size() != 0) begin
            $error("%0d expected result items never arrived", sorted_q.size());
            fail_cnt++;
        end

        $display("Covered %0d input items in %0d runs, %0d of them overflowing the store.",
                 items_sent, runs_done, ovf_runs);
        $display("Checked %0d sorted result items under three back-pressure mixes.",
                 res_checked);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
